@@ hw/rtl/bct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and constants of the barrier count tracker.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int ID_W    = 8;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 16;
  localparam int PIU_W   = 7;
  localparam int OUT_W   = 9;
  localparam int MODE_W  = 3;

  localparam logic [PIU_W-1:0] PIU_RESET = 7'd32;

  // depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MAP      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TASK_END = 3'd4;

  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_MAP,
    CMD_WAIT,
    CMD_UPDATE,
    CMD_TASK_END
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_READY = 2'd1,
    STS_COUNT_ERR = 2'd2,
    STS_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MAP_RD,
    ST_MAP_EV,
    ST_CW_RD,
    ST_CW_EV,
    ST_CU_RD,
    ST_CU_SL,
    ST_CU_OW,
    ST_DECIDE,
    ST_MW_RD,
    ST_MW_WR,
    ST_MU_RD,
    ST_MU_WR,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    cmd_e              kind;
    logic [ID_W-1:0]   barrier_id;
    logic [SLOT_W-1:0] real_id;
    logic [CNT_W-1:0]  producer_count;
    logic [CNT_W-1:0]  consumer_count;
    logic [CNT_W-1:0]  hit_count;
  } cmd_t;

endpackage

@@ hw/rtl/bct_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_front
// Accepts input requests, classifies the mode and queues known commands.
// ----------------------------------------------------------------------------
module bct_front (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bct_pkg::MODE_W-1:0]   mode_i,
  input  logic [bct_pkg::ID_W-1:0]     barrier_id_i,
  input  logic [bct_pkg::SLOT_W-1:0]   real_id_i,
  input  logic [bct_pkg::CNT_W-1:0]    producer_count_i,
  input  logic [bct_pkg::CNT_W-1:0]    consumer_count_i,
  input  logic [bct_pkg::CNT_W-1:0]    hit_count_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output bct_pkg::cmd_t                cmd_o
);
  import bct_pkg::*;

  logic known;

  always_comb begin
    known      = 1'b1;
    cmd_o.kind = CMD_LOAD;
    case (mode_i)
      MODE_LOAD:     cmd_o.kind = CMD_LOAD;
      MODE_MAP:      cmd_o.kind = CMD_MAP;
      MODE_WAIT:     cmd_o.kind = CMD_WAIT;
      MODE_UPDATE:   cmd_o.kind = CMD_UPDATE;
      MODE_TASK_END: cmd_o.kind = CMD_TASK_END;
      default:       known = 1'b0;
    endcase
    cmd_o.barrier_id     = barrier_id_i;
    cmd_o.real_id        = real_id_i;
    cmd_o.producer_count = producer_count_i;
    cmd_o.consumer_count = consumer_count_i;
    cmd_o.hit_count      = hit_count_i;
  end

  // unknown modes are taken and dropped
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i & known;

endmodule

@@ hw/rtl/bct_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_queue
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module bct_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bct_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bct_pkg::cmd_t cmd_o
);
  import bct_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ hw/rtl/bct_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_back
// Executes queued commands against the barrier tables and slot bindings.
// ----------------------------------------------------------------------------
module bct_back #(
  parameter int VIRTUAL_BARRIERS = 256,
  parameter int PHYSICAL_SLOTS   = 64,
  parameter int LIST_DEPTH       = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bct_pkg::PIU_W-1:0]   physical_in_use_i,
  input  logic                        cmd_valid_i,
  input  bct_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [bct_pkg::OUT_W-1:0]   start_after_o,
  output logic [bct_pkg::OUT_W-1:0]   clean_after_o,
  output logic [bct_pkg::OUT_W-1:0]   mapped_count_o,
  output logic [bct_pkg::OUT_W-1:0]   next_unmapped_o
);
  import bct_pkg::*;

  localparam int AW  = $clog2(VIRTUAL_BARRIERS);
  localparam int LW  = $clog2(VIRTUAL_BARRIERS + 1);
  localparam int SW  = $clog2(PHYSICAL_SLOTS);
  localparam int IW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LNW = $clog2(LIST_DEPTH + 1);
  localparam int KW  = $clog2(LIST_DEPTH + 1);
  localparam int NW  = CNT_W + KW;

  back_state_e state_q, state_d;

  // tables
  logic [CNT_W-1:0]  prod_mem  [VIRTUAL_BARRIERS];
  logic [CNT_W-1:0]  cons_mem  [VIRTUAL_BARRIERS];
  logic [SLOT_W-1:0] slot_mem  [VIRTUAL_BARRIERS];
  logic [AW-1:0]     owner_mem [PHYSICAL_SLOTS];
  logic [CNT_W-1:0]  prod_rd_q, cons_rd_q;
  logic [SLOT_W-1:0] slot_rd_q;
  logic [AW-1:0]     own_rd_q;

  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_load_en, wr_prod_en, wr_cons_en;
  logic [CNT_W-1:0]  wr_prod_d, wr_cons_d;
  logic              own_we;
  logic [SW-1:0]     slot_idx;

  logic [PHYSICAL_SLOTS-1:0] slot_valid_q;
  logic                      valid_set, valid_clr;

  logic [ID_W-1:0]   wait_list_q   [LIST_DEPTH];
  logic [ID_W-1:0]   update_list_q [LIST_DEPTH];
  logic              wl_we, ul_we;

  cmd_t              cmd_q;
  logic [LW-1:0]     loaded_q, loaded_d;
  logic [LW-1:0]     next_q, next_d;
  logic [LW-1:0]     mapped_q, mapped_d;
  logic [LNW-1:0]    wlen_q, wlen_d, ulen_q, ulen_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              not_ready_q, not_ready_d, under_q, under_d;
  logic [OUT_W-1:0]  start_q, start_d;
  logic [LW-1:0]     clean_q, clean_d;
  logic [NW-1:0]     need_q, need_d;
  logic [ID_W-1:0]   cur_v_q, cur_v_d;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [OUT_W-1:0]  out_start_q, out_clean_q, out_mapped_q, out_next_q;
  logic              emit;
  status_e           res_status;
  logic [OUT_W-1:0]  res_start, res_clean, res_mapped;

  logic [PIU_W-1:0]  bound;
  logic [PIU_W-1:0]  slot_ext;
  logic [ID_W-1:0]   cur_w, cur_u;
  logic [KW-1:0]     dup_w, dup_u;
  logic              range_err;
  logic              last_w, last_u;
  logic [OUT_W-1:0]  v_plus;
  back_state_e       first_check;

  assign bound    = (physical_in_use_i < PIU_W'(PHYSICAL_SLOTS)) ?
                    physical_in_use_i : PIU_W'(PHYSICAL_SLOTS);
  assign slot_ext = {1'b0, slot_rd_q};
  assign slot_idx = slot_rd_q[SW-1:0];
  assign cur_w    = wait_list_q[idx_q];
  assign cur_u    = update_list_q[idx_q];
  assign last_w   = (LNW'(idx_q) + LNW'(1)) == wlen_q;
  assign last_u   = (LNW'(idx_q) + LNW'(1)) == ulen_q;

  // earlier copies of the current id in each list, and range check
  always_comb begin
    dup_w     = '0;
    dup_u     = '0;
    range_err = 1'b0;
    for (int j = 0; j < LIST_DEPTH; j++) begin
      if (j < int'(idx_q) && wait_list_q[j] == cur_w) begin
        dup_w = dup_w + KW'(1);
      end
      if (j < int'(idx_q) && update_list_q[j] == cur_u) begin
        dup_u = dup_u + KW'(1);
      end
      if (j < int'(wlen_q) && 32'(wait_list_q[j]) >= 32'(VIRTUAL_BARRIERS)) begin
        range_err = 1'b1;
      end
      if (j < int'(ulen_q) && 32'(update_list_q[j]) >= 32'(VIRTUAL_BARRIERS)) begin
        range_err = 1'b1;
      end
    end
  end

  always_comb begin
    if (wlen_q != '0) begin
      first_check = ST_CW_RD;
    end else if (ulen_q != '0) begin
      first_check = ST_CU_RD;
    end else begin
      first_check = ST_DECIDE;
    end
  end

  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    next_d      = next_q;
    mapped_d    = mapped_q;
    wlen_d      = wlen_q;
    ulen_d      = ulen_q;
    idx_d       = idx_q;
    not_ready_d = not_ready_q;
    under_d     = under_q;
    start_d     = start_q;
    clean_d     = clean_q;
    need_d      = need_q;
    cur_v_d     = cur_v_q;
    cmd_pop_o   = 1'b0;
    rd_addr     = '0;
    wr_addr     = AW'(cur_v_q);
    wr_load_en  = 1'b0;
    wr_prod_en  = 1'b0;
    wr_cons_en  = 1'b0;
    wr_prod_d   = prod_rd_q - cmd_q.hit_count;
    wr_cons_d   = cons_rd_q - cmd_q.hit_count;
    own_we      = 1'b0;
    valid_set   = 1'b0;
    valid_clr   = 1'b0;
    wl_we       = 1'b0;
    ul_we       = 1'b0;
    emit        = 1'b0;
    res_status  = STS_OK;
    res_start   = '0;
    res_clean   = '0;
    res_mapped  = '0;
    v_plus      = '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          state_d   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_IDLE;
        case (cmd_q.kind)
          CMD_LOAD: begin
            emit = 1'b1;
            if (loaded_q >= LW'(VIRTUAL_BARRIERS)) begin
              res_status = STS_OVERFLOW;
            end else begin
              wr_addr    = loaded_q[AW-1:0];
              wr_load_en = 1'b1;
              loaded_d   = loaded_q + LW'(1);
            end
          end
          CMD_MAP: begin
            mapped_d = '0;
            state_d  = ST_MAP_RD;
          end
          CMD_WAIT: begin
            emit = 1'b1;
            if (wlen_q >= LNW'(LIST_DEPTH)) begin
              res_status = STS_OVERFLOW;
            end else begin
              wl_we  = 1'b1;
              wlen_d = wlen_q + LNW'(1);
            end
          end
          CMD_UPDATE: begin
            emit = 1'b1;
            if (ulen_q >= LNW'(LIST_DEPTH)) begin
              res_status = STS_OVERFLOW;
            end else begin
              ul_we  = 1'b1;
              ulen_d = ulen_q + LNW'(1);
            end
          end
          CMD_TASK_END: begin
            if (range_err) begin
              emit       = 1'b1;
              res_status = STS_COUNT_ERR;
              wlen_d     = '0;
              ulen_d     = '0;
            end else begin
              not_ready_d = 1'b0;
              under_d     = 1'b0;
              start_d     = '0;
              clean_d     = loaded_q;
              idx_d       = '0;
              state_d     = first_check;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_MAP_RD: begin
        if (next_q < loaded_q) begin
          rd_addr = next_q[AW-1:0];
          state_d = ST_MAP_EV;
        end else begin
          emit       = 1'b1;
          res_mapped = OUT_W'(mapped_q);
          state_d    = ST_IDLE;
        end
      end
      ST_MAP_EV: begin
        if (slot_ext >= bound || slot_valid_q[slot_idx]) begin
          emit       = 1'b1;
          res_mapped = OUT_W'(mapped_q);
          state_d    = ST_IDLE;
        end else begin
          valid_set = 1'b1;
          own_we    = 1'b1;
          next_d    = next_q + LW'(1);
          mapped_d  = mapped_q + LW'(1);
          state_d   = ST_MAP_RD;
        end
      end
      ST_CW_RD: begin
        rd_addr = AW'(cur_w);
        cur_v_d = cur_w;
        need_d  = NW'(dup_w + KW'(1)) * NW'(cmd_q.hit_count);
        v_plus  = OUT_W'(cur_w) + OUT_W'(1);
        if (v_plus > start_q) begin
          start_d = v_plus;
        end
        state_d = ST_CW_EV;
      end
      ST_CW_EV: begin
        // slot must be usable and producers done; consumers must cover hits
        if (slot_ext >= bound || prod_rd_q != '0) begin
          not_ready_d = 1'b1;
        end
        if (NW'(cons_rd_q) < need_q) begin
          under_d = 1'b1;
        end
        if (last_w) begin
          idx_d   = '0;
          state_d = (ulen_q != '0) ? ST_CU_RD : ST_DECIDE;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_CW_RD;
        end
      end
      ST_CU_RD: begin
        rd_addr = AW'(cur_u);
        cur_v_d = cur_u;
        need_d  = NW'(dup_u + KW'(1)) * NW'(cmd_q.hit_count);
        v_plus  = OUT_W'(cur_u) + OUT_W'(1);
        if (v_plus > start_q) begin
          start_d = v_plus;
        end
        if (LW'(cur_u) < clean_q) begin
          clean_d = LW'(cur_u);
        end
        state_d = ST_CU_SL;
      end
      ST_CU_SL: begin
        if (slot_ext >= bound || !slot_valid_q[slot_idx]) begin
          not_ready_d = 1'b1;
        end
        if (NW'(prod_rd_q) < need_q) begin
          under_d = 1'b1;
        end
        state_d = ST_CU_OW;
      end
      ST_CU_OW: begin
        if (own_rd_q != AW'(cur_v_q)) begin
          not_ready_d = 1'b1;
        end
        if (last_u) begin
          idx_d   = '0;
          state_d = ST_DECIDE;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_CU_RD;
        end
      end
      ST_DECIDE: begin
        idx_d = '0;
        if (not_ready_q) begin
          emit       = 1'b1;
          res_status = STS_NOT_READY;
          state_d    = ST_IDLE;
        end else if (under_q) begin
          emit       = 1'b1;
          res_status = STS_COUNT_ERR;
          wlen_d     = '0;
          ulen_d     = '0;
          state_d    = ST_IDLE;
        end else if (wlen_q != '0) begin
          state_d = ST_MW_RD;
        end else if (ulen_q != '0) begin
          state_d = ST_MU_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MW_RD: begin
        rd_addr = AW'(cur_w);
        cur_v_d = cur_w;
        state_d = ST_MW_WR;
      end
      ST_MW_WR: begin
        wr_cons_en = 1'b1;
        if (cons_rd_q == cmd_q.hit_count) begin
          valid_clr = 1'b1;
        end
        if (last_w) begin
          idx_d   = '0;
          state_d = (ulen_q != '0) ? ST_MU_RD : ST_DONE;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_MW_RD;
        end
      end
      ST_MU_RD: begin
        rd_addr = AW'(cur_u);
        cur_v_d = cur_u;
        state_d = ST_MU_WR;
      end
      ST_MU_WR: begin
        wr_prod_en = 1'b1;
        if (last_u) begin
          idx_d   = '0;
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_MU_RD;
        end
      end
      ST_DONE: begin
        emit      = 1'b1;
        res_start = start_q;
        res_clean = OUT_W'(clean_q);
        wlen_d    = '0;
        ulen_d    = '0;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      loaded_q     <= '0;
      next_q       <= '0;
      mapped_q     <= '0;
      wlen_q       <= '0;
      ulen_q       <= '0;
      idx_q        <= '0;
      not_ready_q  <= 1'b0;
      under_q      <= 1'b0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      next_q      <= next_d;
      mapped_q    <= mapped_d;
      wlen_q      <= wlen_d;
      ulen_q      <= ulen_d;
      idx_q       <= idx_d;
      not_ready_q <= not_ready_d;
      under_q     <= under_d;
      if (valid_set) begin
        slot_valid_q[slot_idx] <= 1'b1;
      end else if (valid_clr) begin
        slot_valid_q[slot_idx] <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    clean_q <= clean_d;
    need_q  <= need_d;
    cur_v_q <= cur_v_d;
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      out_status_q <= res_status;
      out_start_q  <= res_start;
      out_clean_q  <= res_clean;
      out_mapped_q <= res_mapped;
      out_next_q   <= OUT_W'(next_q);
    end
    if (wl_we) begin
      wait_list_q[wlen_q[IW-1:0]] <= cmd_q.barrier_id;
    end
    if (ul_we) begin
      update_list_q[ulen_q[IW-1:0]] <= cmd_q.barrier_id;
    end
  end

  // barrier tables: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_load_en) begin
      slot_mem[wr_addr] <= cmd_q.real_id;
    end
    if (wr_load_en || wr_prod_en) begin
      prod_mem[wr_addr] <= wr_load_en ? cmd_q.producer_count : wr_prod_d;
    end
    if (wr_load_en || wr_cons_en) begin
      cons_mem[wr_addr] <= wr_load_en ? cmd_q.consumer_count : wr_cons_d;
    end
    prod_rd_q <= prod_mem[rd_addr];
    cons_rd_q <= cons_mem[rd_addr];
    slot_rd_q <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (own_we) begin
      owner_mem[slot_idx] <= next_q[AW-1:0];
    end
    own_rd_q <= owner_mem[slot_idx];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign start_after_o   = out_start_q;
  assign clean_after_o   = out_clean_q;
  assign mapped_count_o  = out_mapped_q;
  assign next_unmapped_o = out_next_q;

endmodule

@@ hw/rtl/barrier_count_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrier_count_tracker
// Virtual-to-physical barrier binding and producer/consumer count tracking.
// ----------------------------------------------------------------------------
// Use: requests enter on the in_* channel (valid/stall) with a mode: load a
// barrier, map pending barriers, buffer a wait or update id, or end a task.
// Every known mode gives one result on the out_* channel; modes five to
// seven are taken and dropped. The user must write the slot bound on the
// cfg_* channel only while the block is idle; the block does not enforce
// it. The bound resets to 32. A map request binds pending barriers to
// their slots in order until a blocked slot or the last loaded barrier
// ends the walk. A task end runs a check walk over the wait ids and then
// the update ids, then a commit walk over the listed ids; each step waits
// on the registered read of the barrier tables, and each update id in the
// check walk also on the slot owner read. A not-ready task ends after the
// check walk, with no commit walk. The back takes the next request only
// once its result has left, so requests are handled one at a time.
// The front takes new requests into a two-entry queue while the back works,
// and the back holds a finished result in an output register; a stall on
// out_stall_i holds that result and, once the queue fills, raises
// in_stall_o. Reset empties the queue, frees every physical slot and
// clears the load, map and list counters; table contents are not cleared.
// ----------------------------------------------------------------------------
module barrier_count_tracker #(
  parameter int VIRTUAL_BARRIERS = 256,
  parameter int PHYSICAL_SLOTS   = 64,
  parameter int LIST_DEPTH       = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bct_pkg::PIU_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bct_pkg::MODE_W-1:0]   mode_i,
  input  logic [bct_pkg::ID_W-1:0]     barrier_id_i,
  input  logic [bct_pkg::SLOT_W-1:0]   real_id_i,
  input  logic [bct_pkg::CNT_W-1:0]    producer_count_i,
  input  logic [bct_pkg::CNT_W-1:0]    consumer_count_i,
  input  logic [bct_pkg::CNT_W-1:0]    hit_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [bct_pkg::OUT_W-1:0]    start_after_o,
  output logic [bct_pkg::OUT_W-1:0]    clean_after_o,
  output logic [bct_pkg::OUT_W-1:0]    mapped_count_o,
  output logic [bct_pkg::OUT_W-1:0]    next_unmapped_o
);
  import bct_pkg::*;

  logic [PIU_W-1:0] piu_q;
  logic             push, queue_full, pop, queue_valid;
  cmd_t             front_cmd, queue_cmd;

  // slot bound register: always ready, write only while idle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q <= PIU_RESET;
    end else if (cfg_valid_i) begin
      piu_q <= cfg_data_i;
    end
  end

  // front: take and classify requests
  bct_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .barrier_id_i     (barrier_id_i),
    .real_id_i        (real_id_i),
    .producer_count_i (producer_count_i),
    .consumer_count_i (consumer_count_i),
    .hit_count_i      (hit_count_i),
    .queue_full_i     (queue_full),
    .push_o           (push),
    .cmd_o            (front_cmd)
  );

  // hold commands between the two sides
  bct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // back: walk the tables and deliver results
  bct_back #(
    .VIRTUAL_BARRIERS (VIRTUAL_BARRIERS),
    .PHYSICAL_SLOTS   (PHYSICAL_SLOTS),
    .LIST_DEPTH       (LIST_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .physical_in_use_i (piu_q),
    .cmd_valid_i       (queue_valid),
    .cmd_i             (queue_cmd),
    .cmd_pop_o         (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .start_after_o     (start_after_o),
    .clean_after_o     (clean_after_o),
    .mapped_count_o    (mapped_count_o),
    .next_unmapped_o   (next_unmapped_o)
  );

endmodule

@@ hw/rtl/bct_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_chk
// Port-level checks on the result channel of the barrier count tracker.
// ----------------------------------------------------------------------------
module bct_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [bct_pkg::OUT_W-1:0]   start_after_o,
  input logic [bct_pkg::OUT_W-1:0]   clean_after_o,
  input logic [bct_pkg::OUT_W-1:0]   mapped_count_o,
  input logic [bct_pkg::OUT_W-1:0]   next_unmapped_o
);
  import bct_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(next_unmapped_o))
    else $error("result changed while stalled");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_OK |->
      start_after_o == '0 && clean_after_o == '0 && mapped_count_o == '0)
    else $error("failed request reports task or map data");

  a_map_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mapped_count_o != '0 |->
      status_o == STS_OK && start_after_o == '0 && clean_after_o == '0)
    else $error("map result mixed with task data");

endmodule

bind barrier_count_tracker bct_chk u_bct_chk (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the barrier count tracker: a cycle-free predictor
// tracks barrier tables, slot bindings and task lists, and every result of
// the block is compared field by field with the predicted outcome.
// ----------------------------------------------------------------------------
module testbench;
  import bct_pkg::*;

  localparam int NUM_BARRIERS = 256;
  localparam int NUM_SLOTS    = 64;
  localparam int LIST_MAX     = 8;
  // quiet time before a slot-bound write; covers ignored requests in flight
  localparam int SETTLE_CYCLES = 120;
  // outcomes awaiting their result; far more than the block can hold
  localparam int PEND_DEPTH = 16;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [PIU_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [MODE_W-1:0] mode_i = '0;
  logic [ID_W-1:0]   barrier_id_i = '0;
  logic [SLOT_W-1:0] real_id_i = '0;
  logic [CNT_W-1:0]  producer_count_i = '0;
  logic [CNT_W-1:0]  consumer_count_i = '0;
  logic [CNT_W-1:0]  hit_count_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [OUT_W-1:0]  start_after_o;
  logic [OUT_W-1:0]  clean_after_o;
  logic [OUT_W-1:0]  mapped_count_o;
  logic [OUT_W-1:0]  next_unmapped_o;

  barrier_count_tracker DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .barrier_id_i     (barrier_id_i),
    .real_id_i        (real_id_i),
    .producer_count_i (producer_count_i),
    .consumer_count_i (consumer_count_i),
    .hit_count_i      (hit_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .start_after_o    (start_after_o),
    .clean_after_o    (clean_after_o),
    .mapped_count_o   (mapped_count_o),
    .next_unmapped_o  (next_unmapped_o)
  );

  typedef struct {
    status_e          status;
    logic [OUT_W-1:0] start_val;
    logic [OUT_W-1:0] clean_val;
    logic [OUT_W-1:0] mapped_count;
    logic [OUT_W-1:0] next_unmapped;
  } outcome_t;

  // predicted barrier state, kept in step with every accepted request
  logic [CNT_W-1:0]  prod_left [NUM_BARRIERS];
  logic [CNT_W-1:0]  cons_left [NUM_BARRIERS];
  int                slot_of   [NUM_BARRIERS];
  int                owner_id  [NUM_SLOTS];
  bit                owner_valid [NUM_SLOTS];
  int                loaded_n;
  int                map_ptr;
  int                wait_ids [LIST_MAX];
  int                upd_ids  [LIST_MAX];
  int                wait_n;
  int                upd_n;
  int                slot_limit;

  outcome_t          pending_fifo [PEND_DEPTH];
  int                pend_wr = 0;
  int                pend_rd = 0;
  int                mismatches;
  int                requests_sent;
  int                idle_pct;
  int                stall_pct;

  // clock: 10 ns period
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on the run
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int usable_slots();
    return (slot_limit < NUM_SLOTS) ? slot_limit : NUM_SLOTS;
  endfunction

  // Task end: readiness walk, then commit walk with roll-back on underflow.
  function automatic status_e settle_task(input logic [CNT_W-1:0] hit,
                                          output int start, output int clean);
    int bound;
    int v;
    int r;
    logic [CNT_W-1:0] keep_prod [NUM_BARRIERS];
    logic [CNT_W-1:0] keep_cons [NUM_BARRIERS];
    bit               keep_valid [NUM_SLOTS];
    bound = usable_slots();
    start = 0;
    clean = loaded_n;
    for (int i = 0; i < wait_n; i++) begin
      v = wait_ids[i];
      if (slot_of[v] >= bound || prod_left[v] != 0) return STS_NOT_READY;
    end
    for (int i = 0; i < upd_n; i++) begin
      v = upd_ids[i];
      r = slot_of[v];
      if (r >= bound) return STS_NOT_READY;
      if (!owner_valid[r] || owner_id[r] != v) return STS_NOT_READY;
    end
    keep_prod = prod_left;
    keep_cons = cons_left;
    keep_valid = owner_valid;
    for (int i = 0; i < wait_n; i++) begin
      v = wait_ids[i];
      if (prod_left[v] != 0 || cons_left[v] < hit) begin
        prod_left = keep_prod;
        cons_left = keep_cons;
        owner_valid = keep_valid;
        return STS_COUNT_ERR;
      end
      cons_left[v] = cons_left[v] - hit;
      if (v + 1 > start) start = v + 1;
      if (cons_left[v] == 0) owner_valid[slot_of[v]] = 1'b0;
    end
    for (int i = 0; i < upd_n; i++) begin
      v = upd_ids[i];
      if (prod_left[v] < hit) begin
        prod_left = keep_prod;
        cons_left = keep_cons;
        owner_valid = keep_valid;
        return STS_COUNT_ERR;
      end
      prod_left[v] = prod_left[v] - hit;
      if (v + 1 > start) start = v + 1;
      if (v < clean) clean = v;
    end
    return STS_OK;
  endfunction

  // advance the predicted state by one accepted request; queue its outcome
  task automatic predict_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] bid,
                                 input logic [SLOT_W-1:0] rid, input logic [CNT_W-1:0] pc,
                                 input logic [CNT_W-1:0] cc, input logic [CNT_W-1:0] hit);
    outcome_t o;
    int s;
    int c;
    o.status = STS_OK;
    o.start_val = '0;
    o.clean_val = '0;
    o.mapped_count = '0;
    case (mode)
      MODE_LOAD: begin
        if (loaded_n >= NUM_BARRIERS) begin
          o.status = STS_OVERFLOW;
        end else begin
          slot_of[loaded_n] = rid;
          prod_left[loaded_n] = pc;
          cons_left[loaded_n] = cc;
          loaded_n++;
        end
      end
      MODE_MAP: begin
        while (map_ptr < loaded_n && slot_of[map_ptr] < usable_slots()
               && !owner_valid[slot_of[map_ptr]]) begin
          owner_valid[slot_of[map_ptr]] = 1'b1;
          owner_id[slot_of[map_ptr]] = map_ptr;
          map_ptr++;
          o.mapped_count++;
        end
      end
      MODE_WAIT: begin
        if (wait_n >= LIST_MAX) o.status = STS_OVERFLOW;
        else wait_ids[wait_n++] = bid;
      end
      MODE_UPDATE: begin
        if (upd_n >= LIST_MAX) o.status = STS_OVERFLOW;
        else upd_ids[upd_n++] = bid;
      end
      MODE_TASK_END: begin
        o.status = settle_task(hit, s, c);
        if (o.status == STS_OK) begin
          o.start_val = OUT_W'(s);
          o.clean_val = OUT_W'(c);
        end
        if (o.status != STS_NOT_READY) begin
          wait_n = 0;
          upd_n = 0;
        end
      end
      default: return;
    endcase
    o.next_unmapped = OUT_W'(map_ptr);
    pending_fifo[pend_wr % PEND_DEPTH] = o;
    pend_wr++;
  endtask

  task automatic flag(input string msg);
    mismatches++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // result checker: sample at the rising edge, compare with the oldest outcome
  always @(posedge clk_i) begin : check_results
    outcome_t o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pend_wr == pend_rd) begin
        flag("result with no request outstanding");
      end else begin
        o = pending_fifo[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (status_o != o.status)
          flag($sformatf("status %0d, predicted %0d", status_o, o.status));
        if (start_after_o != o.start_val)
          flag($sformatf("start_after_o %0d, predicted %0d", start_after_o, o.start_val));
        if (clean_after_o != o.clean_val)
          flag($sformatf("clean_after_o %0d, predicted %0d", clean_after_o, o.clean_val));
        if (mapped_count_o != o.mapped_count)
          flag($sformatf("mapped_count %0d, predicted %0d", mapped_count_o, o.mapped_count));
        if (next_unmapped_o != o.next_unmapped)
          flag($sformatf("next_unmapped %0d, predicted %0d", next_unmapped_o,
                         o.next_unmapped));
      end
    end
  end

  // receiver back-pressure, changed at the falling edge
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < stall_pct);
  end

  // Send one request. Called at a falling edge; returns at a falling edge with
  // valid still high so back-to-back requests need no bubble.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] bid = '0,
                              input logic [SLOT_W-1:0] rid = '0,
                              input logic [CNT_W-1:0] pc = '0, input logic [CNT_W-1:0] cc = '0,
                              input logic [CNT_W-1:0] hit = '0);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    mode_i = mode;
    barrier_id_i = bid;
    real_id_i = rid;
    producer_count_i = pc;
    consumer_count_i = cc;
    hit_count_i = hit;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(mode, bid, rid, pc, cc, hit);
    if (mode <= MODE_TASK_END) requests_sent++;
    @(negedge clk_i);
  endtask

  // drain, hold off, then write the slot bound
  task automatic set_slot_bound(input int value);
    in_valid_i = 1'b0;
    while (pend_wr != pend_rd) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_data_i = PIU_W'(value);
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    slot_limit = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // one load with small counts and a mostly usable slot
  task automatic send_load();
    int rid;
    int pc;
    int cc;
    rid = ($urandom_range(0, 99) < 93) ? $urandom_range(0, usable_slots() - 1)
                                       : $urandom_range(0, NUM_SLOTS - 1);
    case ($urandom_range(0, 19))
      0:       pc = $urandom_range(0, 65535);
      1, 2, 3: pc = $urandom_range(1, 3);
      default: pc = 0;
    endcase
    case ($urandom_range(0, 39))
      0:       cc = $urandom_range(0, 65535);
      1:       cc = 0;
      default: cc = $urandom_range(1, 3);
    endcase
    send_request(MODE_LOAD, '0, SLOT_W'(rid), CNT_W'(pc), CNT_W'(cc));
  endtask

  // well-formed task: ready waits and owned updates, then task end
  task automatic send_task(input int max_ids);
    int waitable [NUM_BARRIERS];
    int owned [NUM_SLOTS];
    int n_wait;
    int n_owned;
    int hit;
    n_wait = 0;
    n_owned = 0;
    for (int v = 0; v < loaded_n; v++)
      if (prod_left[v] == 0 && slot_of[v] < usable_slots() && cons_left[v] != 0) begin
        waitable[n_wait] = v;
        n_wait++;
      end
    for (int r = 0; r < usable_slots(); r++)
      if (owner_valid[r]) begin
        owned[n_owned] = owner_id[r];
        n_owned++;
      end
    if (n_wait != 0)
      repeat ($urandom_range(0, max_ids))
        send_request(MODE_WAIT, ID_W'(waitable[$urandom_range(0, n_wait - 1)]));
    if (n_owned != 0)
      repeat ($urandom_range(0, max_ids))
        send_request(MODE_UPDATE, ID_W'(owned[$urandom_range(0, n_owned - 1)]));
    case ($urandom_range(0, 49))
      0:          hit = 65535;
      1, 2, 3, 4: hit = $urandom_range(2, 4);
      5, 6, 7:    hit = 0;
      8:          hit = $urandom_range(0, 65535);
      default:    hit = 1;
    endcase
    send_request(MODE_TASK_END, '0, '0, '0, '0, CNT_W'(hit));
  endtask

  task automatic test_directed();
    // unusable slot: map stops at once, task end not ready until bound rises
    send_request(MODE_LOAD, '0, 6'd40, 16'd0, 16'd1);
    send_request(MODE_LOAD, '0, 6'd41, 16'd2, 16'd1);
    send_request(MODE_MAP);
    send_request(MODE_WAIT, 8'd0);
    send_request(MODE_TASK_END, '0, '0, '0, '0, 16'd1);
    set_slot_bound(64);
    send_request(MODE_TASK_END, '0, '0, '0, '0, 16'd1);
    // update of a barrier not yet bound: not ready, then bound by map
    send_request(MODE_UPDATE, 8'd1);
    send_request(MODE_TASK_END, '0, '0, '0, '0, 16'd2);
    send_request(MODE_MAP);
    send_request(MODE_TASK_END, '0, '0, '0, '0, 16'd2);
    // count underflow on a drained consumer, lists dropped
    send_request(MODE_WAIT, 8'd1);
    send_request(MODE_TASK_END, '0, '0, '0, '0, 16'd1);
    send_request(MODE_WAIT, 8'd1);
    send_request(MODE_TASK_END, '0, '0, '0, '0, 16'd1);
    // extreme counts and slots
    send_request(MODE_LOAD, '0, 6'd63, 16'd0, 16'd65535);
    send_request(MODE_LOAD, '0, 6'd0, 16'd65535, 16'd0);
    send_request(MODE_MAP);
    send_request(MODE_WAIT, 8'd2);
    send_request(MODE_UPDATE, 8'd3);
    send_request(MODE_TASK_END, '0, '0, '0, '0, 16'd65535);
    // ignored modes, then list overflow
    send_request(3'd5);
    send_request(3'd6);
    send_request(3'd7);
    repeat (LIST_MAX + 1) send_request(MODE_UPDATE, 8'd3);
    repeat (LIST_MAX + 1) send_request(MODE_WAIT, 8'd2);
    send_request(MODE_TASK_END);
  endtask

  task automatic test_random(input int n_items, input int bound, input int idle,
                             input int stall);
    int stop_at;
    set_slot_bound(bound);
    idle_pct = idle;
    stall_pct = stall;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3:         send_load();
        4, 5, 6:            send_request(MODE_MAP);
        7:                  send_request(MODE_W'($urandom_range(5, 7)),
                                         ID_W'($urandom_range(0, 255)));
        8:                  send_task(LIST_MAX + 2);
        9:                  send_request(MODE_TASK_END, '0, '0, '0, '0,
                                         CNT_W'($urandom_range(0, 65535)));
        default: begin
          if ($urandom_range(0, 1)) send_request(MODE_MAP);
          send_task(3);
        end
      endcase
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // fill the barrier table, then one more load overflows
  task automatic test_table_full();
    set_slot_bound(64);
    while (loaded_n < NUM_BARRIERS) begin
      send_load();
      if ($urandom_range(0, 3) == 0) send_request(MODE_MAP);
    end
    send_load();
  endtask

  initial begin
    loaded_n = 0;
    map_ptr = 0;
    wait_n = 0;
    upd_n = 0;
    slot_limit = PIU_RESET;
    mismatches = 0;
    requests_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    foreach (owner_valid[r]) owner_valid[r] = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    test_random(100, 64, 0, 0);
    test_random(100, 127, 48, 0);
    test_random(40, 1, 0, 48);
    test_random(80, $urandom_range(2, 63), 26, 26);
    test_table_full();
    test_random(80, 64, 26, 26);

    in_valid_i = 1'b0;
    while (pend_wr != pend_rd) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bct_pkg.sv
hw/rtl/bct_front.sv
hw/rtl/bct_queue.sv
hw/rtl/bct_back.sv
hw/rtl/barrier_count_tracker.sv
hw/rtl/bct_chk.sv
tb/sv/testbench.sv
